// File: rtl/core/ipv4p_pkg.sv
package ipv4p_pkg;

  // default text length limit, counting the closing character
  localparam int MAX_CHARS_DEF = 16;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // token limits
  localparam int          NUM_OCTETS = 4;
  localparam logic [2:0]  COUNT_SAT  = 3'd5;
  localparam logic [2:0]  COUNT_FULL = 3'd4;
  localparam logic [3:0]  LEN_SAT    = 4'd15;
  localparam logic [19:0] MAG_SAT    = 20'd65535;
  localparam logic [15:0] POS_LIMIT  = 16'd32767;
  localparam logic [15:0] NEG_LIMIT  = 16'd32768;
  localparam logic [15:0] OCTET_MAX  = 16'd255;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_RANGE     = 2'd2,
    ERR_COUNT     = 2'd3
  } err_t;

  typedef struct packed {
    logic                  in_token;
    logic [3:0]            token_length;
    logic [15:0]           token_magnitude;
    logic                  token_negative;
    logic                  token_malformed;
    logic [2:0]            token_count;
    err_t                  first_error;
    logic [NUM_OCTETS-1:0][7:0] octets;
  } tok_state_t;

  typedef struct packed {
    logic        valid_res;
    err_t        error_code;
    logic [31:0] address;
  } res_t;

  localparam tok_state_t TOK_STATE_CLR = '{
    in_token:        1'b0,
    token_length:    4'd0,
    token_magnitude: 16'd0,
    token_negative:  1'b0,
    token_malformed: 1'b0,
    token_count:     3'd0,
    first_error:     ERR_NONE,
    octets:          '0
  };

  // judge the token that has just ended
  function automatic tok_state_t close_token(input tok_state_t st);
    tok_state_t r;
    logic       bad;
    r   = st;
    bad = 1'b0;
    if (st.in_token) begin
      r.in_token = 1'b0;
      if (st.first_error == ERR_NONE) begin
        bad = st.token_malformed
            | (st.token_length <= {3'b000, st.token_negative})
            | (st.token_negative & (st.token_magnitude == 16'd0))
            | (!st.token_negative & (st.token_magnitude > POS_LIMIT))
            | (st.token_negative & (st.token_magnitude > NEG_LIMIT));
        if (bad) begin
          r.first_error = ERR_MALFORMED;
        end else if (st.token_negative || (st.token_magnitude > OCTET_MAX)) begin
          r.first_error = ERR_RANGE;
        end else begin
          for (int i = 0; i < NUM_OCTETS; i++) begin
            if (st.token_count == 3'(i)) begin
              r.octets[i] = st.token_magnitude[7:0];
            end
          end
          if (st.token_count < COUNT_SAT) begin
            r.token_count = st.token_count + 3'd1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ipv4p_if.sv
interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ip_char;
  logic       last;

  modport source (output valid, output ip_char, output last, input ready);
  modport sink (input valid, input ip_char, input last, output ready);
endinterface

interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [1:0]  error_code;
  logic [31:0] address;

  modport source (output valid, output valid_res, output error_code, output address,
                  input ready);
  modport sink (input valid, input valid_res, input error_code, input address,
                output ready);
endinterface

// File: rtl/core/ipv4p_step.sv
module ipv4p_step (
  input  ipv4p_pkg::tok_state_t st_i,
  input  logic [7:0]            ip_char,
  input  logic                  last,
  input  logic                  skip,
  output ipv4p_pkg::tok_state_t st_o,
  output ipv4p_pkg::res_t       res_o
);
  import ipv4p_pkg::*;

  tok_state_t st_chr;
  tok_state_t st_end;
  logic [19:0] mag_mul;
  err_t        code;

  // next magnitude: ten times the old one plus the digit
  assign mag_mul = 20'({st_i.token_magnitude, 3'b000}) + 20'({st_i.token_magnitude, 1'b0})
                 + 20'(ip_char - CHAR_ZERO);

  // per-character token update
  always_comb begin
    st_chr = st_i;
    if (!skip && (ip_char != CHAR_NUL)) begin
      if (ip_char == CHAR_DOT) begin
        st_chr = close_token(st_i);
      end else begin
        if (!st_i.in_token) begin
          st_chr.in_token        = 1'b1;
          st_chr.token_length    = 4'd0;
          st_chr.token_magnitude = 16'd0;
          st_chr.token_negative  = 1'b0;
          st_chr.token_malformed = 1'b0;
        end
        if ((ip_char == CHAR_MINUS) && (st_chr.token_length == 4'd0)) begin
          st_chr.token_negative = 1'b1;
        end else if ((ip_char >= CHAR_ZERO) && (ip_char <= CHAR_NINE)) begin
          if ((st_chr.token_length > {3'b000, st_chr.token_negative}) &&
              (st_chr.token_magnitude == 16'd0)) begin
            st_chr.token_malformed = 1'b1;
          end
          if (!st_i.in_token) begin
            st_chr.token_magnitude = 16'(ip_char - CHAR_ZERO);
          end else begin
            st_chr.token_magnitude = (mag_mul > MAG_SAT) ? 16'hFFFF : mag_mul[15:0];
          end
        end else begin
          st_chr.token_malformed = 1'b1;
        end
        if (st_chr.token_length < LEN_SAT) begin
          st_chr.token_length = st_chr.token_length + 4'd1;
        end
      end
    end
  end

  // closing of the text
  always_comb begin
    st_end = close_token(st_chr);
    code   = st_end.first_error;
    if ((code == ERR_NONE) && (st_end.token_count != COUNT_FULL)) begin
      code = ERR_COUNT;
    end
    res_o.valid_res  = (code == ERR_NONE);
    res_o.error_code = code;
    res_o.address    = (code == ERR_NONE) ? st_end.octets : 32'd0;
    st_o             = last ? TOK_STATE_CLR : st_chr;
  end

endmodule

// File: rtl/core/ipv4_dotted_decimal_parser_top.sv
// path: a last character waits in the input register for a free result register
// throughput: one character per cycle but for that wait, set by the single-pass
//   step between the input register and the parse state and result registers
// reset: synchronous, active low rst_n; empties both pipeline registers and
//   clears the parse state and character count
module ipv4_dotted_decimal_parser_top #(
  parameter int MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ipv4p_in_if.sink      in_chan,
  ipv4p_out_if.source   out_chan
);
  import ipv4p_pkg::*;

  localparam int CW = $clog2(MAX_CHARS);
  localparam logic [CW-1:0] CHARS_LIM = CW'(MAX_CHARS - 1);

  logic          s1_valid_r;
  logic [7:0]    s1_char_r;
  logic          s1_last_r;
  logic [CW-1:0] chars_r, chars_nxt;
  tok_state_t    st_r, st_nxt;
  res_t          res_c;
  logic          out_valid_r;
  res_t          out_res_r;
  logic          can_proc;
  logic          proc;
  logic          skip;

  // a last character needs the result register free
  assign can_proc = !s1_last_r || !out_valid_r || out_chan.ready;
  assign proc     = s1_valid_r && can_proc;
  assign in_chan.ready = !s1_valid_r || can_proc;
  assign skip     = (chars_r >= CHARS_LIM);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.ip_char;
      s1_last_r <= in_chan.last;
    end
  end

  ipv4p_step u_step (
    .st_i    (st_r),
    .ip_char (s1_char_r),
    .last    (s1_last_r),
    .skip    (skip),
    .st_o    (st_nxt),
    .res_o   (res_c)
  );

  // character count, saturating at the length limit
  always_comb begin
    chars_nxt = chars_r;
    if (s1_last_r) begin
      chars_nxt = '0;
    end else if (!skip) begin
      chars_nxt = (s1_char_r == CHAR_NUL) ? CHARS_LIM : chars_r + CW'(1);
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= TOK_STATE_CLR;
      chars_r <= '0;
    end else if (proc) begin
      st_r    <= st_nxt;
      chars_r <= chars_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last_r) begin
      out_res_r <= res_c;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.valid_res  = out_res_r.valid_res;
  assign out_chan.error_code = out_res_r.error_code;
  assign out_chan.address    = out_res_r.address;

`ifndef SYNTHESIS
  // token count saturates at five
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.token_count <= COUNT_SAT)
    else $error("token count above saturation");

  // character count never passes the limit
  a_chars_lim: assert property (@(posedge clk) disable iff (!rst_n)
    chars_r <= CHARS_LIM)
    else $error("character count above limit");

  // a failed parse carries an error code and a zero address
  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.valid_res |->
      (out_res_r.error_code != ERR_NONE) && (out_res_r.address == 32'd0))
    else $error("error result with address or without code");

  // a last character leaves the parse state cleared
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> (st_r == TOK_STATE_CLR) && (chars_r == '0))
    else $error("parse state not cleared after result");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ipv4p_pkg::*;

  localparam int TEXT_LIMIT = MAX_CHARS_DEF;
  localparam int TOTAL_CHARS = 600;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT = 29;

  typedef logic [7:0] text_t[$];

  // running parse of the address text and the queue of addresses it predicts
  class addr_scoreboard;
    int         chars_taken;
    logic [2:0] tok_count;
    bit         in_tok;
    logic [3:0] tok_len;
    logic [15:0] tok_mag;
    bit         tok_neg;
    bit         tok_bad;
    err_t       first_err;
    logic [7:0] octet_q[NUM_OCTETS];
    res_t       addr_q[$];
    int         errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      chars_taken = 0;
      tok_count   = 3'd0;
      in_tok      = 1'b0;
      tok_len     = 4'd0;
      tok_mag     = 16'd0;
      tok_neg     = 1'b0;
      tok_bad     = 1'b0;
      first_err   = ERR_NONE;
      foreach (octet_q[i]) octet_q[i] = 8'd0;
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    function int pending();
      return addr_q.size();
    endfunction

    // judge the token that just ended; only the first failing token counts
    function void end_token();
      bit malformed;
      if (!in_tok) return;
      in_tok = 1'b0;
      if (first_err != ERR_NONE) return;
      malformed = tok_bad || (tok_len <= tok_neg) || (tok_neg && tok_mag == 16'd0) ||
                  (!tok_neg && tok_mag > 16'd32767) || (tok_neg && tok_mag > 16'd32768);
      if (malformed) begin
        first_err = ERR_MALFORMED;
      end else if (tok_neg || tok_mag > 16'd255) begin
        first_err = ERR_RANGE;
      end else begin
        if (tok_count < 3'd4) octet_q[tok_count[1:0]] = tok_mag[7:0];
        if (tok_count < 3'd5) tok_count = tok_count + 3'd1;
      end
    endfunction

    // one accepted character transfer
    function void note_char(logic [7:0] c, logic fin);
      int unsigned m;
      res_t r;
      if (chars_taken < TEXT_LIMIT - 1) begin
        if (c == CHAR_NUL) begin
          // a nul ends the text early
          chars_taken = TEXT_LIMIT - 1;
        end else begin
          chars_taken++;
          if (c == CHAR_DOT) begin
            end_token();
          end else begin
            if (!in_tok) begin
              in_tok  = 1'b1;
              tok_len = 4'd0;
              tok_mag = 16'd0;
              tok_neg = 1'b0;
              tok_bad = 1'b0;
            end
            if (c == CHAR_MINUS && tok_len == 4'd0) begin
              tok_neg = 1'b1;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              // leading zero makes the token non-canonical
              if (tok_len > tok_neg && tok_mag == 16'd0) tok_bad = 1'b1;
              m = tok_mag * 10 + (c - CHAR_ZERO);
              tok_mag = (m > 65535) ? 16'hFFFF : m[15:0];
            end else begin
              tok_bad = 1'b1;
            end
            if (tok_len < 4'd15) tok_len = tok_len + 4'd1;
          end
        end
      end
      if (!fin) return;
      end_token();
      r.error_code = first_err;
      if (r.error_code == ERR_NONE && tok_count != 3'd4) r.error_code = ERR_COUNT;
      r.valid_res = (r.error_code == ERR_NONE);
      r.address   = r.valid_res ? {octet_q[3], octet_q[2], octet_q[1], octet_q[0]} : 32'd0;
      addr_q.push_back(r);
      clear();
    endfunction

    // compare a result transfer with the oldest predicted address
    function void check_result(logic v, logic [1:0] code, logic [31:0] addr);
      res_t e;
      if (addr_q.size() == 0) begin
        report($sformatf("result with nothing pending: valid=%0b code=%0d addr=%h",
                         v, code, addr));
        return;
      end
      e = addr_q.pop_front();
      if (v !== e.valid_res)
        report($sformatf("valid_res %b, predicted %b", v, e.valid_res));
      if (code !== e.error_code)
        report($sformatf("error_code %0d, predicted %s", code, e.error_code.name()));
      if (addr !== e.address)
        report($sformatf("address %h, predicted %h", addr, e.address));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   chars_sent;
  int   stall_cycles;
  addr_scoreboard sb;

  ipv4p_in_if  in_chan();
  ipv4p_out_if out_chan();

  ipv4_dotted_decimal_parser_top #(.MAX_CHARS(TEXT_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.valid_res, out_chan.error_code, out_chan.address);
    if (rst_n && in_chan.valid && in_chan.ready)
      sb.note_char(in_chan.ip_char, in_chan.last);
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[ipv4_dotted_decimal_parser_top] ERROR");
        $finish;
      end
    end
  end

  // one character transfer, with random gaps before it
  task automatic send_char(logic [7:0] c, logic fin);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.ip_char <= c;
    in_chan.last    <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  // hold the sender until every predicted address has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic text_t as_text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // boundary and broken token spellings
  function automatic string odd_token();
    string odd[$];
    odd = '{"0", "255", "256", "32767", "32768", "-32768", "-32769", "-1", "-0", "00",
            "007", "-", "65535", "99999", "1x", "--2", "+1", "9-"};
    return odd[$urandom_range(odd.size() - 1)];
  endfunction

  // mostly dotted quads with random content, the rest broken or noise
  function automatic text_t random_text();
    text_t t;
    string s;
    int kind;
    int n_tok;
    int bad_pos;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 20)) t.push_back(8'($urandom_range(1, 255)));
      return t;
    end
    n_tok   = (kind >= 80 && kind < 90) ? $urandom_range(1, 6) : 4;
    bad_pos = (kind >= 60 && kind < 80) ? $urandom_range(3) : -1;
    s = "";
    if ($urandom_range(9) == 0) s = ".";
    for (int i = 0; i < n_tok; i++) begin
      if (i != 0) begin
        s = {s, "."};
        if ($urandom_range(6) == 0) s = {s, "."};
      end
      s = {s, (i == bad_pos) ? odd_token() : $sformatf("%0d", $urandom_range(255))};
    end
    if ($urandom_range(9) == 0) s = {s, "."};
    t = as_text(s);
    if (kind >= 90) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(1, 255));
    // rare early nul
    if ($urandom_range(49) == 0) t.insert($urandom_range(t.size() - 1), CHAR_NUL);
    return t;
  endfunction

  initial begin
    text_t t;
    bit mid_drain_done;
    in_chan.valid   = 1'b0;
    in_chan.ip_char = 8'd0;
    in_chan.last    = 1'b0;
    sb = new();
    steady = 1'b0;
    chars_sent = 0;
    mid_drain_done = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: octet extremes, lone minus, negative, leading zero, too large,
    // empty token list, bad character, early nul
    send_text(as_text("255.0.9.1"));
    send_text(as_text("-"));
    send_text(as_text("-5"));
    send_text(as_text("07"));
    send_text(as_text("70000"));
    send_text(as_text("."));
    send_text(as_text("a"));
    t = as_text("1x");
    t.insert(1, CHAR_NUL);
    send_text(t);
    drain();

    // random texts, with a stretch of back-to-back traffic on both sides
    while (chars_sent < TOTAL_CHARS) begin
      steady = (chars_sent >= 250 && chars_sent < 400);
      if (!mid_drain_done && chars_sent >= 450) begin
        drain();
        mid_drain_done = 1'b1;
      end
      send_text(random_text());
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[ipv4_dotted_decimal_parser_top] OK");
    end else begin
      $display("[ipv4_dotted_decimal_parser_top] ERROR");
    end
    $finish;
  end

endmodule
